/* hw/rtl/brk_pkg.sv */
// Shared types, constants and helpers for the two-level Bloch RK4 integrator.
`default_nettype none
package brk_pkg;

	// Widths of the datapath.
	localparam int DATA_W     = 32;
	localparam int RATE_W     = 24;
	localparam int MUL_W      = 34;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = 66;
	localparam int K_W        = 40;
	localparam int T_W        = 44;
	localparam int SUM_W      = 48;
	localparam int SAT_W      = 50;
	localparam int MET_W      = 48;
	localparam int MACC_W     = 50;
	localparam int DIFF_W     = 33;
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int COMP_N     = 8;
	localparam int COMP_W     = 3;
	localparam int RATE_FRAC  = 20;
	localparam int METRIC_SHIFT = 10;

	// Stream and configuration port widths.
	localparam int S_DATA_W   = 72;
	localparam int M_DATA_W   = 120;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPHASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 3'd4;

	// Configuration reset values.
	localparam logic [RATE_W-1:0] STEP_RST    = 24'd209715;
	localparam logic [RATE_W-1:0] DECAY_RST   = 24'd241172;
	localparam logic [RATE_W-1:0] DEPHASE_RST = 24'd524288;
	localparam logic [RATE_W-1:0] DRIVE_RST   = 24'd2202042;
	localparam logic [MET_W-1:0]  THRESH_RST  = 48'd110;

	// Commands.
	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// Matrix components: element times two, plus one for the imaginary part.
	localparam logic [COMP_W-1:0] C_GROUND_RE = 3'd0;
	localparam logic [COMP_W-1:0] C_GROUND_IM = 3'd1;
	localparam logic [COMP_W-1:0] C_UP_RE     = 3'd2;
	localparam logic [COMP_W-1:0] C_UP_IM     = 3'd3;
	localparam logic [COMP_W-1:0] C_DOWN_RE   = 3'd4;
	localparam logic [COMP_W-1:0] C_DOWN_IM   = 3'd5;
	localparam logic [COMP_W-1:0] C_EXC_RE    = 3'd6;
	localparam logic [COMP_W-1:0] C_EXC_IM    = 3'd7;

	localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh4000_0000;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE, ST_DER_A, ST_DER_B, ST_SCL_LO, ST_SCL_HI, ST_SCL_WB, ST_STG_NEXT,
		ST_DIV_GO, ST_DIV_WAIT, ST_DIF_RE, ST_DIF_IM, ST_SQ_RE, ST_SQ_IM,
		ST_ROOT_GO, ST_ROOT_WAIT, ST_MET, ST_MET_ACC, ST_DONE
	} state_t;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic en;
		logic clr;
		logic sub;
		logic shl;
	} mac_ctl_t;

	// Saturate a wide signed value to Q2.30.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = {{(SAT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
		lo = {{(SAT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
		if (v > hi) begin
			return hi[DATA_W-1:0];
		end else if (v < lo) begin
			return lo[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/brk_mac.sv */
// Shared signed multiply-accumulate unit.
`default_nettype none
module brk_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  brk_pkg::mac_ctl_t                   ctl,
	input  logic signed [brk_pkg::MUL_W-1:0]    a,
	input  logic signed [brk_pkg::MUL_W-1:0]    b,
	output logic signed [brk_pkg::ACC_W-1:0]    acc
);
	import brk_pkg::*;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  acc_q;

	// One product, optionally moved up by the rate fraction, added or subtracted.
	always_comb begin
		prod = a * b;
		term = ctl.shl ? ACC_W'(prod <<< RATE_FRAC) : ACC_W'(prod);
		base = ctl.clr ? '0 : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= ctl.sub ? base - term : base + term;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

/* hw/rtl/brk_div6.sv */
// Signed divide by six, truncating toward zero, eight quotient bits per cycle.
`default_nettype none
module brk_div6 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [brk_pkg::SUM_W-1:0]    dividend,
	output logic                                done,
	output logic signed [brk_pkg::SUM_W-1:0]    quotient
);
	import brk_pkg::*;

	localparam int DIGIT_W = 8;
	localparam int STEPS   = SUM_W / DIGIT_W;
	localparam int CNT_W   = $clog2(STEPS);
	localparam logic [3:0] DIVISOR = 4'd6;

	logic [SUM_W-1:0]   mag_q;
	logic [2:0]         rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               neg_q;
	logic               done_q;
	logic [2:0]         rem_c;
	logic [3:0]         part_c;
	logic [DIGIT_W-1:0] qbits_c;

	// Long division of the next eight dividend bits against the remainder.
	always_comb begin
		rem_c   = rem_q;
		qbits_c = '0;
		part_c  = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			part_c = {rem_c, mag_q[SUM_W-1-i]};
			if (part_c >= DIVISOR) begin
				part_c = part_c - DIVISOR;
				qbits_c[DIGIT_W-1-i] = 1'b1;
			end
			rem_c = part_c[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			rem_q  <= '0;
			mag_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mag_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
				neg_q <= dividend[SUM_W-1];
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				mag_q <= {mag_q[SUM_W-DIGIT_W-1:0], qbits_c};
				rem_q <= rem_c;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule
`default_nettype wire

/* hw/rtl/brk_isqrt.sv */
// Integer square root, one result bit per cycle.
`default_nettype none
module brk_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [brk_pkg::RAD_W-1:0]     radicand,
	output logic                          done,
	output logic [brk_pkg::ROOT_W-1:0]    root
);
	import brk_pkg::*;

	logic [RAD_W-1:0] x_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic             run_q;
	logic             done_q;
	logic [RAD_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			x_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q   <= radicand;
				res_q <= '0;
				bit_q <= {2'b01, {(RAD_W-2){1'b0}}};
				run_q <= 1'b1;
			end else if (run_q) begin
				// Digit-by-digit root: try the next bit pair.
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/bloch_rk4_integrator.sv */
// Top level: two-level Bloch RK4 integrator with sequencer and state storage.
//
// Channel   Direction  Handshake           Content
// s_*       in         s_tvalid/s_tready   step or load command, loaded element
// m_*       out        m_tvalid/m_tready   inversion, trace, change metric, settled
// cfg_*     in         cfg_we              register writes, no read-back
//
// A load goes from idle straight to the final state; the length of a step is set by the
// single multiply-accumulate unit (used for each component in each of 4 stages), the
// divide-by-six unit (once per component) and the root unit (once per element).
// Reset clears the matrix to the ground state and the previous matrix to zero.
// s_tready is low while an item is in work; a waiting result holds the block
// in its final state until the output register is free.
`default_nettype none
module bloch_rk4_integrator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// load_index, load_real, load_imag
	input  logic [brk_pkg::S_DATA_W-1:0]       s_tdata,
	// cmd
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// inversion, trace_value, change_metric, settled
	output logic [brk_pkg::M_DATA_W-1:0]       m_tdata,
	input  logic                               cfg_we,
	input  logic [brk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [brk_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import brk_pkg::*;

	state_t state_q, state_d;

	// Configuration registers.
	logic [RATE_W-1:0] step_q, decay_q, dephase_q, drive_q;
	logic [MET_W-1:0]  thresh_q;

	// Matrix storage and work vectors, indexed by component.
	logic signed [DATA_W-1:0] rho_q  [COMP_N];
	logic signed [DATA_W-1:0] prev_q [COMP_N];
	logic signed [DATA_W-1:0] stv_q  [COMP_N];
	logic signed [DATA_W-1:0] nst_q  [COMP_N];
	logic signed [SUM_W-1:0]  sum_q  [COMP_N];

	logic [COMP_W-1:0]        j_q;
	logic [1:0]               st_q;
	logic signed [K_W-1:0]    k_q;
	logic signed [DIFF_W-1:0] dre_q, dim_q;
	logic                     big_q;
	logic [MACC_W-1:0]        metric_q;
	logic                     is_step_q;

	logic                     m_tvalid_q;
	logic [M_DATA_W-1:0]      m_tdata_q;

	// Shared unit connections.
	mac_ctl_t                 mac_ctl;
	logic signed [MUL_W-1:0]  mac_a, mac_b;
	logic signed [ACC_W-1:0]  acc;
	logic                     div_start, div_done;
	logic signed [SUM_W-1:0]  quotient;
	logic                     sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]        root;

	logic                     s_acc;
	logic                     out_free;

	// Derived operands.
	logic signed [MUL_W-1:0]  c_re, c_im, e_re, e_im;
	logic signed [MUL_W-1:0]  g2_op, kd_op, w_op, h_op;
	logic signed [MUL_W-1:0]  own_op;
	logic signed [K_W-1:0]    k_now;
	logic [DIFF_W-1:0]        abs_re, abs_im;
	logic                     big_c;
	logic [DIFF_W-1:0]        ah, bh;
	logic [DIFF_W-1:0]        mag_c;
	logic signed [ACC_W-1:0]  p_half, p_full;
	logic signed [T_W-1:0]    t_c;
	logic signed [SUM_W-1:0]  t_w;
	logic signed [DATA_W-1:0] nst_c;
	logic [MET_W-1:0]         metric_sat;
	logic signed [DATA_W-1:0] inv_c, trace_c;

	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	brk_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	brk_div6 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[j_q]),
		.done     (div_done),
		.quotient (quotient)
	);

	brk_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc[RAD_W-1:0]),
		.done     (sqrt_done),
		.root     (root)
	);

	// Coefficients, coherence and population differences of the stage vector.
	always_comb begin
		g2_op  = MUL_W'({decay_q, 1'b0});
		kd_op  = MUL_W'({2'b00, decay_q} + {1'b0, dephase_q, 1'b0});
		w_op   = MUL_W'(drive_q);
		h_op   = MUL_W'(step_q);
		c_re   = MUL_W'(stv_q[C_UP_RE]) - MUL_W'(stv_q[C_DOWN_RE]);
		c_im   = MUL_W'(stv_q[C_UP_IM]) - MUL_W'(stv_q[C_DOWN_IM]);
		e_re   = MUL_W'(stv_q[C_EXC_RE]) - MUL_W'(stv_q[C_GROUND_RE]);
		e_im   = MUL_W'(stv_q[C_EXC_IM]) - MUL_W'(stv_q[C_GROUND_IM]);
		own_op = MUL_W'(stv_q[j_q]);
		k_now  = K_W'(acc >>> RATE_FRAC);
	end

	// Magnitude prep: absolute values, halved when either part is too wide.
	always_comb begin
		abs_re = dre_q[DIFF_W-1] ? DIFF_W'(-dre_q) : DIFF_W'(dre_q);
		abs_im = dim_q[DIFF_W-1] ? DIFF_W'(-dim_q) : DIFF_W'(dim_q);
		big_c  = ((abs_re | abs_im) >> (DATA_W - 1)) != '0;
		ah     = big_c ? abs_re >> 1 : abs_re;
		bh     = big_c ? abs_im >> 1 : abs_im;
		mag_c  = big_q ? {root, 1'b0} : {1'b0, root};
	end

	// Stage write-back values.
	always_comb begin
		p_half = acc >>> (RATE_FRAC + 1);
		p_full = acc >>> RATE_FRAC;
		t_c    = T_W'(p_full);
		t_w    = (st_q == 2'd1 || st_q == 2'd2) ? SUM_W'(t_c) <<< 1 : SUM_W'(t_c);
		nst_c  = sat32(SAT_W'(rho_q[j_q])
			+ ((st_q[1] == 1'b0) ? SAT_W'(p_half) : SAT_W'(p_full)));
	end

	// Result fields.
	always_comb begin
		metric_sat = (metric_q > MACC_W'({MET_W{1'b1}})) ? {MET_W{1'b1}} : metric_q[MET_W-1:0];
		inv_c      = sat32(SAT_W'(rho_q[C_EXC_RE]) - SAT_W'(rho_q[C_GROUND_RE]));
		trace_c    = sat32(SAT_W'(rho_q[C_EXC_RE]) + SAT_W'(rho_q[C_GROUND_RE]));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = (s_tuser[0] == CMD_LOAD) ? ST_DONE : ST_DER_A;
			end
			ST_DER_A:    state_d = ST_DER_B;
			ST_DER_B:    state_d = ST_SCL_LO;
			ST_SCL_LO:   state_d = ST_SCL_HI;
			ST_SCL_HI:   state_d = ST_SCL_WB;
			ST_SCL_WB:   state_d = (j_q == C_EXC_IM) ? ST_STG_NEXT : ST_DER_A;
			ST_STG_NEXT: state_d = (st_q == 2'd3) ? ST_DIV_GO : ST_DER_A;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) state_d = (j_q == C_EXC_IM) ? ST_DIF_RE : ST_DIV_GO;
			end
			ST_DIF_RE:   state_d = ST_DIF_IM;
			ST_DIF_IM:   state_d = ST_SQ_RE;
			ST_SQ_RE:    state_d = ST_SQ_IM;
			ST_SQ_IM:    state_d = ST_ROOT_GO;
			ST_ROOT_GO:  state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: begin
				if (sqrt_done) state_d = ST_MET;
			end
			ST_MET:      state_d = ST_MET_ACC;
			ST_MET_ACC:  state_d = (j_q == C_GROUND_RE) ? ST_DONE : ST_DIF_RE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: shared unit control and operands.
	always_comb begin
		mac_ctl    = '0;
		mac_a      = '0;
		mac_b      = '0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		s_tready   = (state_q == ST_IDLE);
		case (state_q)
			ST_DER_A: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = 1'b1;
				case (j_q)
					C_GROUND_RE, C_GROUND_IM: begin
						mac_a = g2_op;
						mac_b = MUL_W'(j_q[0] ? stv_q[C_EXC_IM] : stv_q[C_EXC_RE]);
					end
					C_EXC_RE, C_EXC_IM: begin
						mac_ctl.sub = 1'b1;
						mac_a = g2_op;
						mac_b = own_op;
					end
					default: begin
						mac_ctl.sub = 1'b1;
						mac_a = kd_op;
						mac_b = own_op;
					end
				endcase
			end
			ST_DER_B: begin
				mac_ctl.en = 1'b1;
				mac_a      = w_op;
				case (j_q)
					C_GROUND_RE: begin mac_ctl.sub = 1'b1; mac_b = c_im; end
					C_GROUND_IM: begin mac_b = c_re; end
					C_UP_RE:     begin mac_b = e_im; end
					C_UP_IM:     begin mac_ctl.sub = 1'b1; mac_b = e_re; end
					C_DOWN_RE:   begin mac_ctl.sub = 1'b1; mac_b = e_im; end
					C_DOWN_IM:   begin mac_b = e_re; end
					C_EXC_RE:    begin mac_b = c_im; end
					default:     begin mac_ctl.sub = 1'b1; mac_b = c_re; end
				endcase
			end
			ST_SCL_LO: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a       = h_op;
				mac_b       = MUL_W'({1'b0, k_now[RATE_FRAC-1:0]});
			end
			ST_SCL_HI: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.shl = 1'b1;
				mac_a       = h_op;
				mac_b       = MUL_W'($signed(k_q[K_W-1:RATE_FRAC]));
			end
			ST_DIV_GO: div_start = 1'b1;
			ST_SQ_RE: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a       = MUL_W'(ah);
				mac_b       = MUL_W'(ah);
			end
			ST_SQ_IM: begin
				mac_ctl.en = 1'b1;
				mac_a      = MUL_W'(bh);
				mac_b      = MUL_W'(bh);
			end
			ST_ROOT_GO: sqrt_start = 1'b1;
			ST_MET: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a       = h_op;
				mac_b       = MUL_W'(mag_c);
			end
			default: ;
		endcase
	end

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			j_q       <= '0;
			st_q      <= '0;
			is_step_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					j_q       <= '0;
					st_q      <= '0;
					is_step_q <= (s_tuser[0] == CMD_STEP);
				end
				ST_SCL_WB:   j_q <= j_q + 1'b1;
				ST_STG_NEXT: st_q <= st_q + 1'b1;
				ST_DIV_WAIT: if (div_done) j_q <= j_q + 1'b1;
				ST_DIF_RE:   j_q <= j_q + 1'b1;
				ST_DIF_IM:   j_q <= j_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Matrix state: loads, updates and the previous-step copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMP_N; i++) begin
				rho_q[i]  <= (i == C_GROUND_RE) ? ONE_Q30 : '0;
				prev_q[i] <= '0;
			end
		end else begin
			if (s_acc && s_tuser[0] == CMD_LOAD) begin
				rho_q[{s_tdata[1:0], 1'b0}] <= s_tdata[33:2];
				rho_q[{s_tdata[1:0], 1'b1}] <= s_tdata[65:34];
			end
			if (state_q == ST_DIV_WAIT && div_done) begin
				rho_q[j_q] <= sat32(SAT_W'(rho_q[j_q]) + SAT_W'(quotient));
			end
			if (state_q == ST_DIF_RE || state_q == ST_DIF_IM) begin
				prev_q[j_q] <= rho_q[j_q];
			end
		end
	end

	// Work registers of the integration.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < COMP_N; i++) stv_q[i] <= rho_q[i];
			end
			ST_SCL_LO: k_q <= k_now;
			ST_SCL_WB: begin
				nst_q[j_q] <= nst_c;
				sum_q[j_q] <= (st_q == 2'd0) ? t_w : sum_q[j_q] + t_w;
			end
			ST_STG_NEXT: begin
				for (int i = 0; i < COMP_N; i++) stv_q[i] <= nst_q[i];
			end
			ST_DIF_RE: dre_q <= DIFF_W'(rho_q[j_q]) - DIFF_W'(prev_q[j_q]);
			ST_DIF_IM: dim_q <= DIFF_W'(rho_q[j_q]) - DIFF_W'(prev_q[j_q]);
			ST_SQ_RE:  big_q <= big_c;
			default: ;
		endcase
	end

	// Change metric accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= '0;
		end else if (state_q == ST_IDLE) begin
			metric_q <= '0;
		end else if (state_q == ST_MET_ACC) begin
			metric_q <= metric_q + MACC_W'(MET_W'(acc >>> METRIC_SHIFT));
		end
	end

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_RST;
			decay_q   <= DECAY_RST;
			dephase_q <= DEPHASE_RST;
			drive_q   <= DRIVE_RST;
			thresh_q  <= THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP:    step_q    <= cfg_data[RATE_W-1:0];
				CFG_DECAY:   decay_q   <= cfg_data[RATE_W-1:0];
				CFG_DEPHASE: dephase_q <= cfg_data[RATE_W-1:0];
				CFG_DRIVE:   drive_q   <= cfg_data[RATE_W-1:0];
				CFG_THRESH:  thresh_q  <= cfg_data[MET_W-1:0];
				default: ;
			endcase
		end
	end

	// Output register: one transaction per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {7'd0,
				is_step_q && (metric_sat < thresh_q),
				is_step_q ? metric_sat : {MET_W{1'b0}},
				trace_c, inv_c};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The divider and root unit only finish while the sequencer waits on them.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_WAIT) else $error("divider finished out of turn");

	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_ROOT_WAIT) else $error("root unit finished out of turn");

	// An accepted item closes the input until it is finished.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready) else $error("input open while an item is in work");

	// A load goes straight to the result.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser[0] == CMD_LOAD) |=> state_q == ST_DONE)
		else $error("load did not go to the result");

endmodule
`default_nettype wire
